/* hdl/slpc_pkg.sv */
// Shared constants and types for the sorted list partition check block.
package slpc_pkg;

   localparam int LIST_DEPTH_DEFAULT = 256;
   localparam int ID_WIDTH_DEFAULT   = 32;

   localparam int NUM_LISTS = 4;

   localparam logic [9:0] COUNT_MAX          = 10'd1023;
   localparam logic [9:0] MIN_COVERAGE_RESET = 10'd5;

   localparam logic [2:0] CSR_ADDR_MIN_COVERAGE = 3'd0;

   localparam logic FUNC_APPEND   = 1'b0;
   localparam logic FUNC_EVALUATE = 1'b1;

   typedef struct packed {
      logic append;
      logic evaluate;
      logic release_result;
   } slpc_ctrl_type;

   typedef struct packed {
      logic idle;
      logic done;
      logic overflow;
   } slpc_status_type;

endpackage

/* hdl/slpc_merge.sv */
// List store, length counters and two-pointer merge engine over the four lists.
module slpc_merge #(
   parameter int LIST_DEPTH = slpc_pkg::LIST_DEPTH_DEFAULT,
   parameter int ID_WIDTH   = slpc_pkg::ID_WIDTH_DEFAULT
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  slpc_pkg::slpc_ctrl_type               ctrl,
   input  logic [1:0]                            list_select,
   input  logic [ID_WIDTH-1:0]                   read_id,
   output slpc_pkg::slpc_status_type             status,
   output logic [$clog2(2*LIST_DEPTH+1)-1:0]     cis_count,
   output logic [$clog2(2*LIST_DEPTH+1)-1:0]     trans_count
);

   localparam int IDX_W  = $clog2(LIST_DEPTH);
   localparam int LEN_W  = $clog2(LIST_DEPTH+1);
   localparam int CNT_W  = $clog2(2*LIST_DEPTH+1);
   localparam int ADDR_W = 2 + IDX_W;
   localparam int MEM_D  = slpc_pkg::NUM_LISTS * (2**IDX_W);

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_START = 2'd1;
   localparam logic [1:0] ST_MERGE = 2'd2;
   localparam logic [1:0] ST_HOLD  = 2'd3;

   logic [ID_WIDTH-1:0] list_mem_ff [MEM_D];

   logic [1:0]          state_ff, state_in;
   logic [1:0]          pair_ff, pair_in;
   logic [LEN_W-1:0]    len_ff [slpc_pkg::NUM_LISTS];
   logic [LEN_W-1:0]    len_in [slpc_pkg::NUM_LISTS];
   logic                ovf_ff, ovf_in;
   logic [LEN_W-1:0]    ptr_a_ff, ptr_a_in, ptr_b_ff, ptr_b_in;
   logic [CNT_W-1:0]    cis_ff, cis_in, trans_ff, trans_in;
   logic [ID_WIDTH-1:0] rd_a_ff, rd_b_ff;

   logic [1:0]          list_a, list_b;
   logic [LEN_W-1:0]    len_a, len_b, len_sel;
   logic                ids_equal, a_greater, adv_a, adv_b;
   logic [LEN_W-1:0]    ptr_a_nx, ptr_b_nx;
   logic                pair_end, pair_empty, last_pair;
   logic                wr_en;
   logic [ADDR_W-1:0]   wr_addr, rd_addr_a, rd_addr_b;
   logic [IDX_W-1:0]    rd_idx_a, rd_idx_b;

   assign list_a  = {1'b0, pair_ff[0]};
   assign list_b  = {1'b1, pair_ff[0] ^ pair_ff[1]};
   assign len_a   = len_ff[list_a];
   assign len_b   = len_ff[list_b];
   assign len_sel = len_ff[list_select];

   assign ids_equal = (rd_a_ff == rd_b_ff);
   assign a_greater = (rd_a_ff > rd_b_ff);
   assign adv_a     = !a_greater;
   assign adv_b     = ids_equal || a_greater;
   assign ptr_a_nx  = ptr_a_ff + LEN_W'(adv_a);
   assign ptr_b_nx  = ptr_b_ff + LEN_W'(adv_b);

   assign pair_end   = (ptr_a_nx >= len_a) || (ptr_b_nx >= len_b);
   assign pair_empty = (len_a == '0) || (len_b == '0);
   assign last_pair  = (pair_ff == 2'd3);

   assign wr_en   = ctrl.append && (state_ff == ST_IDLE) && (len_sel < LEN_W'(LIST_DEPTH));
   assign wr_addr = {list_select, len_sel[IDX_W-1:0]};

   assign rd_idx_a  = (state_ff == ST_MERGE) ? ptr_a_nx[IDX_W-1:0] : '0;
   assign rd_idx_b  = (state_ff == ST_MERGE) ? ptr_b_nx[IDX_W-1:0] : '0;
   assign rd_addr_a = {list_a, rd_idx_a};
   assign rd_addr_b = {list_b, rd_idx_b};

   always_comb begin
      state_in = state_ff;
      pair_in  = pair_ff;
      len_in   = len_ff;
      ovf_in   = ovf_ff;
      ptr_a_in = ptr_a_ff;
      ptr_b_in = ptr_b_ff;
      cis_in   = cis_ff;
      trans_in = trans_ff;
      case (state_ff)
         ST_IDLE: begin
            if (ctrl.append) begin
               if (len_sel < LEN_W'(LIST_DEPTH)) begin
                  len_in[list_select] = len_sel + LEN_W'(1);
               end else begin
                  ovf_in = 1'b1;
               end
            end
            if (ctrl.evaluate) begin
               state_in = ST_START;
               pair_in  = 2'd0;
               cis_in   = '0;
               trans_in = '0;
            end
         end
         ST_START: begin
            ptr_a_in = '0;
            ptr_b_in = '0;
            if (!pair_empty) begin
               state_in = ST_MERGE;
            end else if (last_pair) begin
               state_in = ST_HOLD;
            end else begin
               pair_in = pair_ff + 2'd1;
            end
         end
         ST_MERGE: begin
            ptr_a_in = ptr_a_nx;
            ptr_b_in = ptr_b_nx;
            if (ids_equal) begin
               if (pair_ff[1]) begin
                  trans_in = trans_ff + CNT_W'(1);
               end else begin
                  cis_in = cis_ff + CNT_W'(1);
               end
            end
            if (pair_end) begin
               if (last_pair) begin
                  state_in = ST_HOLD;
               end else begin
                  pair_in  = pair_ff + 2'd1;
                  state_in = ST_START;
               end
            end
         end
         ST_HOLD: begin
            if (ctrl.release_result) begin
               for (int k = 0; k < slpc_pkg::NUM_LISTS; k++) begin
                  len_in[k] = '0;
               end
               ovf_in   = 1'b0;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         pair_ff  <= 2'd0;
         ovf_ff   <= 1'b0;
         for (int k = 0; k < slpc_pkg::NUM_LISTS; k++) begin
            len_ff[k] <= '0;
         end
      end else begin
         state_ff <= state_in;
         pair_ff  <= pair_in;
         ovf_ff   <= ovf_in;
         len_ff   <= len_in;
      end
   end

   always_ff @(posedge clock) begin
      ptr_a_ff <= ptr_a_in;
      ptr_b_ff <= ptr_b_in;
      cis_ff   <= cis_in;
      trans_ff <= trans_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         list_mem_ff[wr_addr] <= read_id;
      end
      rd_a_ff <= list_mem_ff[rd_addr_a];
      rd_b_ff <= list_mem_ff[rd_addr_b];
   end

   assign status.idle     = (state_ff == ST_IDLE);
   assign status.done     = (state_ff == ST_HOLD);
   assign status.overflow = ovf_ff;
   assign cis_count       = cis_ff;
   assign trans_count     = trans_ff;

endmodule

/* hdl/sorted_list_partition_check_core.sv */
// Top level of the sorted list partition check: stream ports, register port, result stage.
//
//  channel  direction  handshake              payload
//  req      in         req_tvalid/req_tready  req_tdata read_id, req_tuser func, list_select
//  rsp      out        rsp_tvalid/rsp_tready  rsp_tdata verdict, counts, overflow flag
//  csr      in/out     psel/penable/pready    min_coverage at byte address 0
//
//  An append item leaves the block idle; the next item is taken in the following cycle.
//  An evaluate item walks four list pairs through the two read ports of the list
//  store, each pair with a start step and then its merge steps, before the result
//  loads; req_tready stays low meanwhile.
//  A waiting result stalls the block only if a second evaluate finishes before it is taken.
//  Reset is synchronous; lists start empty and min_coverage starts at 5.
module sorted_list_partition_check_core #(
   parameter int LIST_DEPTH = slpc_pkg::LIST_DEPTH_DEFAULT,
   parameter int ID_WIDTH   = slpc_pkg::ID_WIDTH_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,  // [31:0] read_id
   input  logic [2:0]  req_tuser,  // [0] func, [2:1] list_select
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata   // [0] valid_partition, [10:1] cis_count,
                                   // [20:11] trans_count, [21] list_overflow, [23:22] zero
);

   localparam int CNT_W = $clog2(2*LIST_DEPTH+1);
   localparam int CMP_W = (CNT_W > 10) ? CNT_W : 10;

   logic [9:0]                 min_cov_ff, min_cov_in;
   logic                       csr_write;
   logic                       req_accept;
   slpc_pkg::slpc_ctrl_type    ctrl;
   slpc_pkg::slpc_status_type  status;
   logic [CNT_W-1:0]           cis_raw, trans_raw;
   logic [CMP_W-1:0]           cis_w, trans_w, cov_w, max_w;
   logic [9:0]                 cis_sat, trans_sat;
   logic                       verdict;
   logic                       out_free;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic [23:0]                rsp_data_ff;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign min_cov_in = (csr_write && (csr_paddr == slpc_pkg::CSR_ADDR_MIN_COVERAGE))
                       ? csr_pwdata[9:0] : min_cov_ff;
   assign csr_prdata = (csr_paddr == slpc_pkg::CSR_ADDR_MIN_COVERAGE)
                       ? {22'd0, min_cov_ff} : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         min_cov_ff <= slpc_pkg::MIN_COVERAGE_RESET;
      end else begin
         min_cov_ff <= min_cov_in;
      end
   end

   assign req_tready = status.idle;
   assign req_accept = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;

   assign ctrl.append         = req_accept && (req_tuser[0] == slpc_pkg::FUNC_APPEND);
   assign ctrl.evaluate       = req_accept && (req_tuser[0] == slpc_pkg::FUNC_EVALUATE);
   assign ctrl.release_result = status.done && out_free;

   slpc_merge #(
      .LIST_DEPTH (LIST_DEPTH),
      .ID_WIDTH   (ID_WIDTH)
   ) u_merge (
      .clock       (clock),
      .reset       (reset),
      .ctrl        (ctrl),
      .list_select (req_tuser[2:1]),
      .read_id     (req_tdata[ID_WIDTH-1:0]),
      .status      (status),
      .cis_count   (cis_raw),
      .trans_count (trans_raw)
   );

   assign cis_w   = CMP_W'(cis_raw);
   assign trans_w = CMP_W'(trans_raw);
   assign cov_w   = CMP_W'(min_cov_ff);
   assign max_w   = CMP_W'(slpc_pkg::COUNT_MAX);

   assign cis_sat   = (cis_w > max_w) ? slpc_pkg::COUNT_MAX : cis_w[9:0];
   assign trans_sat = (trans_w > max_w) ? slpc_pkg::COUNT_MAX : trans_w[9:0];
   assign verdict   = ((trans_w == '0) && (cis_w >= cov_w)) ||
                      ((cis_w == '0) && (trans_w >= cov_w));

   assign rsp_valid_in = ctrl.release_result ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.release_result) begin
         rsp_data_ff <= {2'b00, status.overflow, trans_sat, cis_sat, verdict};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   a_eval_busy: assert property (@(posedge clock) disable iff (reset)
      ctrl.evaluate |=> !req_tready)
      else $error("block took an item right after an evaluate item");

   a_load_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(status.done))
      else $error("result appeared without a finished merge");

   a_verdict_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[0] |-> (rsp_tdata[10:1] == 10'd0) || (rsp_tdata[20:11] == 10'd0))
      else $error("valid partition reported with both cis and trans matches");

endmodule
